FILE: rtl/orbcam_pkg.sv
// Shared types, constants and helper functions of the orbit camera rotator.
package orbcam_pkg;

   localparam int TRIG_FRAC_BITS_DEF = 16;

   // Shared multiplier operand and product widths, and the saturation input width.
   localparam int MUL_W  = 33;
   localparam int PROD_W = 66;
   localparam int SAT_W  = 68;

   // Angle units are 1/128 degree.
   localparam int TURN_UNITS   = 46080;
   localparam int OCTANT_UNITS = 5760;

   // Radians per angle unit in Q48, split for two narrow multiplies.
   localparam longint RAD_PER_UNIT_Q48 = 64'd38380196138;
   localparam longint RAD_HI = RAD_PER_UNIT_Q48 >> 18;
   localparam longint RAD_LO = RAD_PER_UNIT_Q48 & 64'h3FFFF;
   localparam longint ONE_Q30 = 64'd1 << 30;

   // Reciprocals used to divide the series terms by their factorial steps.
   localparam longint RECIP_BASE = 64'd1 << 32;
   localparam longint RECIP_2  = RECIP_BASE / 2;
   localparam longint RECIP_6  = RECIP_BASE / 6;
   localparam longint RECIP_12 = RECIP_BASE / 12;
   localparam longint RECIP_20 = RECIP_BASE / 20;
   localparam longint RECIP_30 = RECIP_BASE / 30;
   localparam longint RECIP_42 = RECIP_BASE / 42;
   localparam longint RECIP_56 = RECIP_BASE / 56;
   localparam longint RECIP_72 = RECIP_BASE / 72;
   localparam longint RECIP_90 = RECIP_BASE / 90;

   typedef enum logic [2:0] {
      REG_ANGLE_STEP    = 3'd0,
      REG_TILT_MAX      = 3'd1,
      REG_TILT_MIN      = 3'd2,
      REG_PAN_MAX       = 3'd3,
      REG_PAN_MIN       = 3'd4,
      REG_FULL_CIRCLE   = 3'd5,
      REG_LOOK_DISTANCE = 3'd6,
      REG_LOOK_HEIGHT   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic        [10:0] angle_step;
      logic signed [14:0] tilt_max;
      logic signed [14:0] tilt_min;
      logic signed [16:0] pan_max;
      logic signed [16:0] pan_min;
      logic        [15:0] full_circle;
      logic        [23:0] look_distance;
      logic signed [24:0] look_height;
   } cfg_type;

   typedef struct packed {
      logic tilt_up;
      logic tilt_down;
      logic pan_right;
      logic pan_left;
   } key_type;

   // Divisor of series term n: sine uses (2n)(2n+1), cosine (2n-1)(2n).
   function automatic logic [6:0] series_div(input logic cos_sel, input logic [2:0] n);
      logic [6:0] d;
      case ({cos_sel, n})
         4'b0001: d = 7'd6;
         4'b0010: d = 7'd20;
         4'b0011: d = 7'd42;
         4'b0100: d = 7'd72;
         4'b1001: d = 7'd2;
         4'b1010: d = 7'd12;
         4'b1011: d = 7'd30;
         4'b1100: d = 7'd56;
         4'b1101: d = 7'd90;
         default: d = 7'd1;
      endcase
      return d;
   endfunction

   function automatic logic [31:0] series_recip(input logic cos_sel, input logic [2:0] n);
      logic [31:0] m;
      case ({cos_sel, n})
         4'b0001: m = 32'(RECIP_6);
         4'b0010: m = 32'(RECIP_20);
         4'b0011: m = 32'(RECIP_42);
         4'b0100: m = 32'(RECIP_72);
         4'b1001: m = 32'(RECIP_2);
         4'b1010: m = 32'(RECIP_12);
         4'b1011: m = 32'(RECIP_30);
         4'b1100: m = 32'(RECIP_56);
         4'b1101: m = 32'(RECIP_90);
         default: m = 32'd0;
      endcase
      return m;
   endfunction

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [31:0] s;
      if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31])) begin
         s = v[31:0];
      end else if (v[SAT_W-1]) begin
         s = 32'sh8000_0000;
      end else begin
         s = 32'sh7FFF_FFFF;
      end
      return s;
   endfunction

endpackage

FILE: rtl/orbcam_if.sv
// Request and response channel interfaces of the orbit camera rotator.
interface orbcam_req_if;
   logic              valid;
   logic              ready;
   logic              key_tilt_up;
   logic              key_tilt_down;
   logic              key_pan_right;
   logic              key_pan_left;
   logic signed [31:0] player_x;
   logic signed [31:0] player_y;
   logic signed [31:0] player_z;
   logic signed [31:0] move_x;
   logic signed [31:0] move_z;

   modport source (output valid, key_tilt_up, key_tilt_down, key_pan_right, key_pan_left,
                   player_x, player_y, player_z, move_x, move_z, input ready);
   modport sink (input valid, key_tilt_up, key_tilt_down, key_pan_right, key_pan_left,
                 player_x, player_y, player_z, move_x, move_z, output ready);
endinterface

interface orbcam_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] moved_x;
   logic signed [31:0] moved_y;
   logic signed [31:0] moved_z;
   logic signed [31:0] cam_x;
   logic signed [31:0] cam_y;
   logic signed [31:0] cam_z;
   logic signed [31:0] look_y;
   logic signed [16:0] pan_now;
   logic signed [14:0] tilt_now;

   modport source (output valid, moved_x, moved_y, moved_z, cam_x, cam_y, cam_z, look_y,
                   pan_now, tilt_now, input ready);
   modport sink (input valid, moved_x, moved_y, moved_z, cam_x, cam_y, cam_z, look_y,
                 pan_now, tilt_now, output ready);
endinterface

FILE: rtl/orbcam_mul.sv
// Shared signed multiplier with a registered product.
module orbcam_mul
   import orbcam_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod_ff
);

   // One product per cycle, available in the following cycle.
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

FILE: rtl/orbcam_angle.sv
// Pan and tilt angle state with the per-frame key stepping, clamping and wrapping.
module orbcam_angle
   import orbcam_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  key_type            keys,
   input  cfg_type            cfg,
   output logic signed [16:0] pan_ff,
   output logic signed [14:0] tilt_ff
);

   logic signed [18:0] step_p;
   logic signed [18:0] circle_p;
   logic signed [18:0] pan_a;
   logic signed [18:0] pan_b;
   logic signed [16:0] pan_in;
   logic signed [16:0] step_t;
   logic signed [16:0] tilt_a;
   logic signed [14:0] tilt_in;

   function automatic logic signed [16:0] clamp_pan(input logic signed [18:0] v);
      logic signed [16:0] c;
      if (v < -19'sd65536) begin
         c = -17'sd65536;
      end else if (v > 19'sd65535) begin
         c = 17'sd65535;
      end else begin
         c = v[16:0];
      end
      return c;
   endfunction

   // Pan steps right then left; each step saturates and wraps at its limit.
   always_comb begin
      step_p   = $signed({8'd0, cfg.angle_step});
      circle_p = $signed({3'd0, cfg.full_circle});
      pan_a    = 19'(pan_ff);
      if (keys.pan_right) begin
         pan_a = 19'(clamp_pan(pan_a + step_p));
         if (pan_a >= 19'(cfg.pan_max)) begin
            pan_a = 19'(clamp_pan(pan_a - circle_p));
         end
      end
      pan_b = pan_a;
      if (keys.pan_left) begin
         pan_b = 19'(clamp_pan(pan_b - step_p));
         if (pan_b <= 19'(cfg.pan_min)) begin
            pan_b = 19'(clamp_pan(pan_b + circle_p));
         end
      end
      pan_in = pan_b[16:0];
   end

   // Tilt steps up then down, each checked against its own limit.
   always_comb begin
      step_t = $signed({6'd0, cfg.angle_step});
      tilt_a = 17'(tilt_ff);
      if (keys.tilt_up) begin
         tilt_a = tilt_a + step_t;
         if (tilt_a >= 17'(cfg.tilt_max)) begin
            tilt_a = 17'(cfg.tilt_max);
         end
      end
      if (keys.tilt_down) begin
         tilt_a = tilt_a - step_t;
         if (tilt_a <= 17'(cfg.tilt_min)) begin
            tilt_a = 17'(cfg.tilt_min);
         end
      end
      if (tilt_a < -17'sd16384) begin
         tilt_in = -15'sd16384;
      end else if (tilt_a > 17'sd16383) begin
         tilt_in = 15'sd16383;
      end else begin
         tilt_in = tilt_a[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_ff  <= '0;
         tilt_ff <= 15'sd5120;
      end else if (load) begin
         pan_ff  <= pan_in;
         tilt_ff <= tilt_in;
      end
   end

endmodule

FILE: rtl/orbit_camera_angle_rotator_unit.sv
// Top level of the orbit camera rotator: sequencer around one shared multiplier.
//
// Each item on req_chan is one frame: four key flags, the player position and
// a move vector. The keys step the pan and tilt angles at once; then sine and
// cosine of both angles are formed by an octant reduction and a short power
// series, the move vector is turned by pan, and the camera point is placed
// around the raised look-at point. One item on rsp_chan answers each frame.
// Each item passes through the single multiplier step by step: 52 steps per
// angle for the reduction and the series, then 10 steps for the final products.
// A new item can be taken in the cycle after the result is registered, never
// before the block is through with the last one.
// req_chan.ready is high only while the sequencer is idle. The result sits in
// an output register, so a stalled receiver only holds the finished result
// while the next item is accepted and computed; the sequencer waits at its
// last step until the output register is free.
// Reset (synchronous, active high) returns pan to 0, tilt to 40 degrees and
// all registers on csr_ to their defaults; csr_ writes take effect at once.
module orbit_camera_angle_rotator_unit
   import orbcam_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   orbcam_req_if.sink   req_chan,
   orbcam_rsp_if.source rsp_chan,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [24:0]  csr_wdata
);

   localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
   localparam int FRAC_SH = 30 - TRIG_FRAC_BITS;
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (TRIG_FRAC_BITS - 1);
   localparam logic [31:0] TRIG_ONE = 32'd1 << TRIG_FRAC_BITS;
   localparam logic [31:0] FRAC_HALF = 32'd1 << (FRAC_SH - 1);
   localparam logic signed [17:0] TURN18 = 18'sd46080;

   typedef enum logic [23:0] {
      ST_IDLE = 24'h000001,
      ST_RED  = 24'h000002,
      ST_XH   = 24'h000004,
      ST_XL   = 24'h000008,
      ST_XS   = 24'h000010,
      ST_SQ   = 24'h000020,
      ST_SQW  = 24'h000040,
      ST_TM   = 24'h000080,
      ST_QM   = 24'h000100,
      ST_QD   = 24'h000200,
      ST_QR   = 24'h000400,
      ST_AC   = 24'h000800,
      ST_TRIG = 24'h001000,
      ST_F1   = 24'h002000,
      ST_F2   = 24'h004000,
      ST_F3   = 24'h008000,
      ST_F4   = 24'h010000,
      ST_F5   = 24'h020000,
      ST_F6   = 24'h040000,
      ST_F7   = 24'h080000,
      ST_F8   = 24'h100000,
      ST_F9   = 24'h200000,
      ST_F10  = 24'h400000,
      ST_DONE = 24'h800000
   } state_type;

   state_type state_ff;
   cfg_type   cfg_ff;
   key_type   keys;

   logic req_fire;
   logic signed [16:0] pan_cur;
   logic signed [14:0] tilt_cur;

   logic signed [31:0] px_ff, py_ff, pz_ff, mx_ff, mz_ff;
   logic               sel_ff;
   logic [2:0]         k_ff;
   logic [12:0]        t_ff;
   logic [29:0]        xa_ff, x_ff, x2_ff, tmp_ff, q_ff;
   logic [30:0]        term_ff, acc_ff, ss_ff;
   logic [7:0]         r_ff;
   logic               cos_ff;
   logic [2:0]         n_ff;
   logic signed [TRIG_W-1:0] sp_ff, cp_ff, stl_ff, ctl_ff;
   logic signed [PROD_W-1:0] acc64_ff;
   logic signed [31:0] mvx_ff, mvz_ff, camx_ff, camz_ff;
   logic signed [25:0] vy_ff, vz_ff;
   logic               rsp_valid_ff;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;

   // Angle reduction signals.
   logic signed [17:0] a18, m1, m2, m3;
   logic [15:0] mu, r_red;
   logic [2:0]  k_red;
   logic [12:0] t_red;

   // Series and result signals.
   logic [6:0]  div_n;
   logic [29:0] qf;
   logic [30:0] acc_in;
   logic        last_term;
   logic [29:0] rem_diff;
   logic signed [TRIG_W-1:0] so, co, so_sw, co_sw, s_in, c_in;
   logic signed [PROD_W-1:0] rnd_prod, rnd_diff, rnd_sum;
   logic signed [31:0] ly;

   function automatic logic signed [PROD_W-1:0] rnd_q(input logic signed [PROD_W-1:0] v);
      return (v + RND_HALF) >>> TRIG_FRAC_BITS;
   endfunction

   function automatic logic signed [TRIG_W-1:0] to_frac(input logic [30:0] v);
      logic [31:0] w;
      w = ({1'b0, v} + FRAC_HALF) >> FRAC_SH;
      if (w > TRIG_ONE) begin
         w = TRIG_ONE;
      end
      return $signed(w[TRIG_W-1:0]);
   endfunction

   assign keys = '{tilt_up:   req_chan.key_tilt_up,   tilt_down: req_chan.key_tilt_down,
                   pan_right: req_chan.key_pan_right, pan_left:  req_chan.key_pan_left};
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   orbcam_angle u_angle (
      .clock   (clock),
      .reset   (reset),
      .load    (req_fire),
      .keys    (keys),
      .cfg     (cfg_ff),
      .pan_ff  (pan_cur),
      .tilt_ff (tilt_cur)
   );

   orbcam_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_step    <= 11'd384;
         cfg_ff.tilt_max      <= 15'sd10240;
         cfg_ff.tilt_min      <= -15'sd10240;
         cfg_ff.pan_max       <= 17'sd23040;
         cfg_ff.pan_min       <= -17'sd23040;
         cfg_ff.full_circle   <= 16'd46080;
         cfg_ff.look_distance <= 24'd128000;
         cfg_ff.look_height   <= 25'sd25600;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_ANGLE_STEP:    cfg_ff.angle_step    <= csr_wdata[10:0];
            REG_TILT_MAX:      cfg_ff.tilt_max      <= $signed(csr_wdata[14:0]);
            REG_TILT_MIN:      cfg_ff.tilt_min      <= $signed(csr_wdata[14:0]);
            REG_PAN_MAX:       cfg_ff.pan_max       <= $signed(csr_wdata[16:0]);
            REG_PAN_MIN:       cfg_ff.pan_min       <= $signed(csr_wdata[16:0]);
            REG_FULL_CIRCLE:   cfg_ff.full_circle   <= csr_wdata[15:0];
            REG_LOOK_DISTANCE: cfg_ff.look_distance <= csr_wdata[23:0];
            REG_LOOK_HEIGHT:   cfg_ff.look_height   <= $signed(csr_wdata[24:0]);
            default: ;
         endcase
      end
   end

   // Reduce the selected angle to one turn, then to an octant offset.
   always_comb begin
      a18 = sel_ff ? 18'(tilt_cur) : 18'(pan_cur);
      m1  = (a18 < 0) ? a18 + TURN18 : a18;
      m2  = (m1 < 0) ? m1 + TURN18 : m1;
      m3  = (m2 >= TURN18) ? m2 - TURN18 : m2;
      mu  = m3[15:0];
      k_red = 3'd0;
      for (int j = 1; j < 8; j++) begin
         if (mu >= 16'(j * OCTANT_UNITS)) begin
            k_red = 3'(j);
         end
      end
      r_red = mu - 16'(k_red) * 16'(OCTANT_UNITS);
      t_red = k_red[0] ? 13'(16'(OCTANT_UNITS) - r_red) : 13'(r_red);
   end

   // Series term update: quotient correction and alternating accumulation.
   always_comb begin
      div_n     = series_div(cos_ff, n_ff);
      qf        = q_ff + ((r_ff >= {1'b0, div_n}) ? 30'd1 : 30'd0);
      acc_in    = n_ff[0] ? acc_ff - {1'b0, qf} : acc_ff + {1'b0, qf};
      last_term = cos_ff ? (n_ff == 3'd5) : (n_ff == 3'd4);
      rem_diff  = tmp_ff - prod_ff[29:0];
   end

   // Octant symmetry applied to the series results.
   always_comb begin
      so    = to_frac(ss_ff);
      co    = to_frac(acc_ff);
      so_sw = k_ff[0] ? co : so;
      co_sw = k_ff[0] ? so : co;
      case (k_ff[2:1])
         2'd0: begin s_in = so_sw;  c_in = co_sw;  end
         2'd1: begin s_in = co_sw;  c_in = -so_sw; end
         2'd2: begin s_in = -so_sw; c_in = -co_sw; end
         2'd3: begin s_in = -co_sw; c_in = so_sw;  end
         default: begin s_in = so_sw; c_in = co_sw; end
      endcase
   end

   assign rnd_prod = rnd_q(prod_ff);
   assign rnd_diff = rnd_q(acc64_ff - prod_ff);
   assign rnd_sum  = rnd_q(acc64_ff + prod_ff);
   assign ly       = sat32(SAT_W'(py_ff) + SAT_W'(cfg_ff.look_height));

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_XH: begin
            mul_a = MUL_W'($signed({1'b0, t_ff}));
            mul_b = MUL_W'(RAD_HI);
         end
         ST_XL: begin
            mul_a = MUL_W'($signed({1'b0, t_ff}));
            mul_b = MUL_W'(RAD_LO);
         end
         ST_SQ: begin
            mul_a = MUL_W'($signed({1'b0, x_ff}));
            mul_b = MUL_W'($signed({1'b0, x_ff}));
         end
         ST_TM: begin
            mul_a = MUL_W'($signed({1'b0, term_ff}));
            mul_b = MUL_W'($signed({1'b0, x2_ff}));
         end
         ST_QM: begin
            mul_a = MUL_W'($signed({1'b0, prod_ff[59:30]}));
            mul_b = $signed({1'b0, series_recip(cos_ff, n_ff)});
         end
         ST_QD: begin
            mul_a = MUL_W'($signed({1'b0, prod_ff[61:32]}));
            mul_b = MUL_W'($signed({1'b0, div_n}));
         end
         ST_F1: begin mul_a = MUL_W'(mx_ff); mul_b = MUL_W'(cp_ff); end
         ST_F2: begin mul_a = MUL_W'(mz_ff); mul_b = MUL_W'(sp_ff); end
         ST_F3: begin mul_a = MUL_W'(mx_ff); mul_b = MUL_W'(sp_ff); end
         ST_F4: begin mul_a = MUL_W'(mz_ff); mul_b = MUL_W'(cp_ff); end
         ST_F5: begin
            mul_a = MUL_W'(stl_ff);
            mul_b = MUL_W'($signed({1'b0, cfg_ff.look_distance}));
         end
         ST_F6: begin
            mul_a = MUL_W'(ctl_ff);
            mul_b = MUL_W'($signed({1'b0, cfg_ff.look_distance}));
         end
         ST_F8: begin mul_a = -MUL_W'(sp_ff); mul_b = MUL_W'(vz_ff); end
         ST_F9: begin mul_a = MUL_W'(cp_ff);  mul_b = MUL_W'(vz_ff); end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         cos_ff       <= 1'b0;
         n_ff         <= 3'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  sel_ff   <= 1'b0;
                  state_ff <= ST_RED;
               end
            end
            ST_RED:  state_ff <= ST_XH;
            ST_XH:   state_ff <= ST_XL;
            ST_XL:   state_ff <= ST_XS;
            ST_XS:   state_ff <= ST_SQ;
            ST_SQ:   state_ff <= ST_SQW;
            ST_SQW: begin
               cos_ff   <= 1'b0;
               n_ff     <= 3'd1;
               state_ff <= ST_TM;
            end
            ST_TM:   state_ff <= ST_QM;
            ST_QM:   state_ff <= ST_QD;
            ST_QD:   state_ff <= ST_QR;
            ST_QR:   state_ff <= ST_AC;
            ST_AC: begin
               if (last_term && !cos_ff) begin
                  cos_ff   <= 1'b1;
                  n_ff     <= 3'd1;
                  state_ff <= ST_TM;
               end else if (last_term) begin
                  state_ff <= ST_TRIG;
               end else begin
                  n_ff     <= n_ff + 3'd1;
                  state_ff <= ST_TM;
               end
            end
            ST_TRIG: begin
               if (!sel_ff) begin
                  sel_ff   <= 1'b1;
                  state_ff <= ST_RED;
               end else begin
                  state_ff <= ST_F1;
               end
            end
            ST_F1:   state_ff <= ST_F2;
            ST_F2:   state_ff <= ST_F3;
            ST_F3:   state_ff <= ST_F4;
            ST_F4:   state_ff <= ST_F5;
            ST_F5:   state_ff <= ST_F6;
            ST_F6:   state_ff <= ST_F7;
            ST_F7:   state_ff <= ST_F8;
            ST_F8:   state_ff <= ST_F9;
            ST_F9:   state_ff <= ST_F10;
            ST_F10:  state_ff <= ST_DONE;
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Datapath registers written by the sequencer steps.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         px_ff <= req_chan.player_x;
         py_ff <= req_chan.player_y;
         pz_ff <= req_chan.player_z;
         mx_ff <= req_chan.move_x;
         mz_ff <= req_chan.move_z;
      end
      case (state_ff)
         ST_RED: begin
            k_ff <= k_red;
            t_ff <= t_red;
         end
         ST_XL:  xa_ff <= prod_ff[29:0];
         ST_XS:  x_ff  <= xa_ff + 30'(prod_ff[30:18]);
         ST_SQW: begin
            x2_ff   <= prod_ff[59:30];
            term_ff <= {1'b0, x_ff};
            acc_ff  <= {1'b0, x_ff};
         end
         ST_QM:  tmp_ff <= prod_ff[59:30];
         ST_QD:  q_ff   <= prod_ff[61:32];
         ST_QR:  r_ff   <= rem_diff[7:0];
         ST_AC: begin
            if (last_term && !cos_ff) begin
               ss_ff   <= acc_in;
               acc_ff  <= 31'(ONE_Q30);
               term_ff <= 31'(ONE_Q30);
            end else begin
               acc_ff  <= acc_in;
               term_ff <= {1'b0, qf};
            end
         end
         ST_TRIG: begin
            if (!sel_ff) begin
               sp_ff <= s_in;
               cp_ff <= c_in;
            end else begin
               stl_ff <= s_in;
               ctl_ff <= c_in;
            end
         end
         ST_F2:  acc64_ff <= prod_ff;
         ST_F3:  mvx_ff   <= sat32(SAT_W'(px_ff) + SAT_W'(rnd_diff));
         ST_F4:  acc64_ff <= prod_ff;
         ST_F5:  mvz_ff   <= sat32(SAT_W'(pz_ff) + SAT_W'(rnd_sum));
         ST_F6:  vy_ff    <= rnd_prod[25:0];
         ST_F7:  vz_ff    <= -$signed(rnd_prod[25:0]);
         ST_F9:  camx_ff  <= sat32(SAT_W'(mvx_ff) + SAT_W'(rnd_prod));
         ST_F10: camz_ff  <= sat32(SAT_W'(mvz_ff) + SAT_W'(rnd_prod));
         default: ;
      endcase
   end

   // Output register for the finished item.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_chan.moved_x  <= mvx_ff;
         rsp_chan.moved_y  <= py_ff;
         rsp_chan.moved_z  <= mvz_ff;
         rsp_chan.cam_x    <= camx_ff;
         rsp_chan.cam_y    <= sat32(SAT_W'(ly) + SAT_W'(vy_ff));
         rsp_chan.cam_z    <= camz_ff;
         rsp_chan.look_y   <= ly;
         rsp_chan.pan_now  <= pan_cur;
         rsp_chan.tilt_now <= tilt_cur;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // An accepted item keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("request ready right after an item was accepted");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_term_count: assert property (@(posedge clock) disable iff (reset)
      (n_ff >= 3'd1) && (n_ff <= 3'd5))
      else $error("series term count out of range");

   // A result becomes valid only when the sequencer hands it over.
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result valid raised outside the hand-over step");
`endif

endmodule

FILE: tb/orbit_camera_angle_rotator_unit_tb.sv
// Self-checking testbench of the orbit camera angle rotator with its own pose predictor.
module orbit_camera_angle_rotator_unit_tb;
   import orbcam_pkg::*;

   localparam int     FRAC      = TRIG_FRAC_BITS_DEF;
   localparam longint PAN_LO    = -65536;
   localparam longint PAN_HI    = 65535;
   localparam longint TILT_LO   = -16384;
   localparam longint TILT_HI   = 16383;
   localparam int     LONG_HOLD = 400;
   localparam int     SETTLE    = 130;

   typedef struct packed {
      key_type            keys;
      logic signed [31:0] player_x;
      logic signed [31:0] player_y;
      logic signed [31:0] player_z;
      logic signed [31:0] move_x;
      logic signed [31:0] move_z;
   } frame_type;

   typedef struct packed {
      logic signed [31:0] moved_x;
      logic signed [31:0] moved_y;
      logic signed [31:0] moved_z;
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic signed [31:0] look_y;
      logic signed [16:0] pan_now;
      logic signed [14:0] tilt_now;
   } pose_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [24:0] csr_wdata;

   orbcam_req_if req_chan ();
   orbcam_rsp_if rsp_chan ();

   orbit_camera_angle_rotator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   frame_type pending_frames[$];
   pose_type  expected_poses[$];
   cfg_type   cfg_now;
   longint    pan_state;
   longint    tilt_state;
   int        err_count;
   bit        burst_mode;
   bit        long_hold_req;
   bit        long_hold_done;
   int        hold_left;
   int        send_gap;
   int        recv_gap;

   // Clock with period 8.
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mismatch report: one line per failure.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0d (%h), expected %0d (%h)", what, $signed(got), got,
               $signed(want), want);
      err_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat_coord(input longint v);
      return clamp(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   // Round a product with FRAC fraction bits to nearest, ties toward plus infinity.
   function automatic longint round_frac(input longint v);
      longint w;
      w = v + (64'sd1 <<< (FRAC - 1));
      if (w >= 0) return w >>> FRAC;
      return -((-w + (64'sd1 <<< FRAC) - 1) >>> FRAC);
   endfunction

   function automatic longint q30_to_frac(input longint q);
      longint v;
      v = (q + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
      return v > (64'sd1 <<< FRAC) ? (64'sd1 <<< FRAC) : v;
   endfunction

   // Sine and cosine by octant reduction and a short power series in Q30.
   function automatic void sin_cos(input longint angle, output longint s, output longint c);
      longint m, k, r, t, x, x2, term, ss, cc, so, co, tmp;
      m = angle % TURN_UNITS;
      if (m < 0) m += TURN_UNITS;
      k = m / OCTANT_UNITS;
      r = m % OCTANT_UNITS;
      t = k[0] ? OCTANT_UNITS - r : r;
      x = (t * RAD_PER_UNIT_Q48) >>> 18;
      x2 = (x * x) >>> 30;
      ss = x;
      term = x;
      for (int n = 1; n <= 4; n++) begin
         term = ((term * x2) >>> 30) / ((2 * n) * (2 * n + 1));
         ss = n[0] ? ss - term : ss + term;
      end
      cc = ONE_Q30;
      term = ONE_Q30;
      for (int n = 1; n <= 5; n++) begin
         term = ((term * x2) >>> 30) / ((2 * n - 1) * (2 * n));
         cc = n[0] ? cc - term : cc + term;
      end
      so = q30_to_frac(ss);
      co = q30_to_frac(cc);
      if (k[0]) begin
         tmp = so;
         so = co;
         co = tmp;
      end
      case (k >> 1)
         0: begin s = so;  c = co;  end
         1: begin s = co;  c = -so; end
         2: begin s = -so; c = -co; end
         default: begin s = -co; c = so; end
      endcase
   endfunction

   // Step the angles by the keys and work out the moved player and camera pose.
   function automatic pose_type predict_pose(input frame_type f);
      pose_type p;
      longint tl, pn, st, sp, cp, stl, ctl, mvx, mvz, ly, vy, vz, hx, hz;
      tl = tilt_state;
      pn = pan_state;
      st = longint'(cfg_now.angle_step);
      if (f.keys.tilt_up) begin
         tl += st;
         if (tl >= cfg_now.tilt_max) tl = cfg_now.tilt_max;
      end
      if (f.keys.tilt_down) begin
         tl -= st;
         if (tl <= cfg_now.tilt_min) tl = cfg_now.tilt_min;
      end
      tl = clamp(tl, TILT_LO, TILT_HI);
      if (f.keys.pan_right) begin
         pn = clamp(pn + st, PAN_LO, PAN_HI);
         if (pn >= cfg_now.pan_max)
            pn = clamp(pn - longint'(cfg_now.full_circle), PAN_LO, PAN_HI);
      end
      if (f.keys.pan_left) begin
         pn = clamp(pn - st, PAN_LO, PAN_HI);
         if (pn <= cfg_now.pan_min)
            pn = clamp(pn + longint'(cfg_now.full_circle), PAN_LO, PAN_HI);
      end
      tilt_state = tl;
      pan_state = pn;
      sin_cos(pn, sp, cp);
      sin_cos(tl, stl, ctl);
      mvx = sat_coord(f.player_x + round_frac(f.move_x * cp - f.move_z * sp));
      mvz = sat_coord(f.player_z + round_frac(f.move_x * sp + f.move_z * cp));
      ly  = sat_coord(f.player_y + longint'(cfg_now.look_height));
      vy  = round_frac(stl * longint'(cfg_now.look_distance));
      vz  = -round_frac(ctl * longint'(cfg_now.look_distance));
      hx  = round_frac(-sp * vz);
      hz  = round_frac(cp * vz);
      p.moved_x  = mvx[31:0];
      p.moved_y  = f.player_y;
      p.moved_z  = mvz[31:0];
      p.cam_x    = 32'(sat_coord(mvx + hx));
      p.cam_y    = 32'(sat_coord(ly + vy));
      p.cam_z    = 32'(sat_coord(mvz + hz));
      p.look_y   = ly[31:0];
      p.pan_now  = pn[16:0];
      p.tilt_now = tl[14:0];
      return p;
   endfunction

   // Driver: offers queued items with random gaps and predicts each accepted one.
   always @(posedge clock) begin
      frame_type f;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            f = {req_chan.key_tilt_up, req_chan.key_tilt_down, req_chan.key_pan_right,
                 req_chan.key_pan_left, req_chan.player_x, req_chan.player_y,
                 req_chan.player_z, req_chan.move_x, req_chan.move_z};
            expected_poses.push_back(predict_pose(f));
            send_gap = burst_mode ? 0 : $urandom_range(0, 4);
            if (send_gap == 0 && pending_frames.size() != 0) begin
               f = pending_frames.pop_front();
               req_chan.key_tilt_up   <= f.keys.tilt_up;
               req_chan.key_tilt_down <= f.keys.tilt_down;
               req_chan.key_pan_right <= f.keys.pan_right;
               req_chan.key_pan_left  <= f.keys.pan_left;
               req_chan.player_x      <= f.player_x;
               req_chan.player_y      <= f.player_y;
               req_chan.player_z      <= f.player_z;
               req_chan.move_x        <= f.move_x;
               req_chan.move_z        <= f.move_z;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end else if (!req_chan.valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_frames.size() != 0) begin
               f = pending_frames.pop_front();
               req_chan.valid         <= 1'b1;
               req_chan.key_tilt_up   <= f.keys.tilt_up;
               req_chan.key_tilt_down <= f.keys.tilt_down;
               req_chan.key_pan_right <= f.keys.pan_right;
               req_chan.key_pan_left  <= f.keys.pan_left;
               req_chan.player_x      <= f.player_x;
               req_chan.player_y      <= f.player_y;
               req_chan.player_z      <= f.player_z;
               req_chan.move_x        <= f.move_x;
               req_chan.move_z        <= f.move_z;
            end
         end
      end
   end

   // Monitor: random receiver stalls, one long hold, and field checks of each item.
   always @(posedge clock) begin
      pose_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_gap = 0;
         hold_left = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_poses.size() == 0) begin
               $display("MISMATCH unexpected result item, pan %0d", rsp_chan.pan_now);
               err_count++;
            end else begin
               want = expected_poses.pop_front();
               check_field("moved_x", rsp_chan.moved_x, want.moved_x);
               check_field("moved_y", rsp_chan.moved_y, want.moved_y);
               check_field("moved_z", rsp_chan.moved_z, want.moved_z);
               check_field("cam_x", rsp_chan.cam_x, want.cam_x);
               check_field("cam_y", rsp_chan.cam_y, want.cam_y);
               check_field("cam_z", rsp_chan.cam_z, want.cam_z);
               check_field("look_y", rsp_chan.look_y, want.look_y);
               check_field("pan_now", 32'(rsp_chan.pan_now), 32'(want.pan_now));
               check_field("tilt_now", 32'(rsp_chan.tilt_now), 32'(want.tilt_now));
            end
            recv_gap = burst_mode ? 0 : $urandom_range(0, 4);
         end
         if (long_hold_req && !long_hold_done) begin
            hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if ((rsp_chan.valid && rsp_chan.ready) || !rsp_chan.ready) begin
            if (recv_gap == 0) begin
               rsp_chan.ready <= 1'b1;
            end else begin
               rsp_chan.ready <= 1'b0;
               recv_gap--;
            end
         end
      end
   end

   task automatic push_frame(input logic [3:0] keys, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input logic [31:0] mx, input logic [31:0] mz);
      pending_frames.push_back({keys, px, py, pz, mx, mz});
   endtask

   // Coordinates: half moderate values, the rest full-range words and the two extremes.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 7))
         0, 1: return $urandom;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
      endcase
   endfunction

   // Wait until the block is idle with no item pending or expected.
   task automatic wait_drain();
      do @(posedge clock);
      while (pending_frames.size() != 0 || req_chan.valid || expected_poses.size() != 0);
   endtask

   // Write all registers, one per clock, while the block is idle.
   task automatic apply_settings(input cfg_type c);
      logic [24:0] vals[8];
      vals[REG_ANGLE_STEP]    = 25'(c.angle_step);
      vals[REG_TILT_MAX]      = 25'(c.tilt_max);
      vals[REG_TILT_MIN]      = 25'(c.tilt_min);
      vals[REG_PAN_MAX]       = 25'(c.pan_max);
      vals[REG_PAN_MIN]       = 25'(c.pan_min);
      vals[REG_FULL_CIRCLE]   = 25'(c.full_circle);
      vals[REG_LOOK_DISTANCE] = 25'(c.look_distance);
      vals[REG_LOOK_HEIGHT]   = c.look_height;
      for (int i = 0; i < 8; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= 3'(i);
         csr_wdata <= vals[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_now = c;
   endtask

   function automatic cfg_type rand_settings();
      cfg_type c;
      c.angle_step    = 11'($urandom_range(0, 1280));
      c.tilt_max      = 15'($signed($urandom_range(0, 23040)) - 11520);
      c.tilt_min      = 15'($signed($urandom_range(0, 23040)) - 11520);
      c.pan_max       = 17'($signed($urandom_range(0, 92160)) - 46080);
      c.pan_min       = 17'($signed($urandom_range(0, 92160)) - 46080);
      c.full_circle   = 16'($urandom_range(0, 46080));
      c.look_distance = 24'($urandom);
      c.look_height   = 25'($urandom);
      return c;
   endfunction

   // Stimulus: directed frames, then random phases under varied settings.
   initial begin
      cfg_type c;
      cfg_type defaults;
      err_count = 0;
      burst_mode = 1'b0;
      long_hold_req = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      {req_chan.key_tilt_up, req_chan.key_tilt_down} = 2'b00;
      {req_chan.key_pan_right, req_chan.key_pan_left} = 2'b00;
      req_chan.player_x = '0;
      req_chan.player_y = '0;
      req_chan.player_z = '0;
      req_chan.move_x = '0;
      req_chan.move_z = '0;
      rsp_chan.ready = 1'b0;
      defaults = '{angle_step: 11'd384, tilt_max: 15'sd10240, tilt_min: -15'sd10240,
                   pan_max: 17'sd23040, pan_min: -17'sd23040, full_circle: 16'd46080,
                   look_distance: 24'd128000, look_height: 25'sd25600};
      cfg_now = defaults;
      pan_state = 0;
      tilt_state = 5120;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Default settings: every key pattern, coordinate extremes and saturation.
      for (int k = 0; k < 16; k++)
         push_frame(4'(k), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord());
      push_frame(4'b0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_frame(4'b0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000);
      push_frame(4'b1010, 0, 0, 0, 0, 0);
      wait_drain();

      // Extreme settings: no pan wrap, a large step, full distance and the most negative height.
      c = '{angle_step: 11'd1280, tilt_max: 15'sd11520, tilt_min: -15'sd11520,
            pan_max: 17'sd46080, pan_min: -17'sd46080, full_circle: 16'd0,
            look_distance: 24'hFF_FFFF, look_height: -25'sd16777216};
      apply_settings(c);
      for (int i = 0; i < 8; i++)
         push_frame(i < 4 ? 4'b1010 : 4'b0101, rand_coord(), 32'h8000_0000, rand_coord(),
                    rand_coord(), rand_coord());
      wait_drain();

      // Tilt lower clamp above the upper one, narrow pan limits, zero distance.
      c = '{angle_step: 11'd700, tilt_max: -15'sd2000, tilt_min: 15'sd3000,
            pan_max: 17'sd1000, pan_min: -17'sd1000, full_circle: 16'd46080,
            look_distance: 24'd0, look_height: 25'sd16777215};
      apply_settings(c);
      for (int k = 0; k < 6; k++)
         push_frame(4'($urandom_range(0, 15)), rand_coord(), 32'h7FFF_FFFF, rand_coord(),
                    rand_coord(), rand_coord());
      wait_drain();

      // Random phases; one without idling, one with a long receiver hold.
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 0) c = defaults;
         else c = rand_settings();
         if (ph == 5) c.angle_step = 11'd0;
         if (ph == 6) c.full_circle = 16'd0;
         apply_settings(c);
         burst_mode = (ph == 2);
         for (int i = 0; i < 115; i++)
            push_frame(4'($urandom_range(0, 15)), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord());
         if (ph == 3) begin
            repeat (200) @(posedge clock);
            long_hold_req = 1'b1;
         end
         wait_drain();
         burst_mode = 1'b0;
      end

      repeat (SETTLE) @(posedge clock);
      if (expected_poses.size() != 0) begin
         $display("MISMATCH %0d expected result items never arrived", expected_poses.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
rtl/orbcam_pkg.sv
rtl/orbcam_if.sv
rtl/orbcam_mul.sv
rtl/orbcam_angle.sv
rtl/orbit_camera_angle_rotator_unit.sv
tb/orbit_camera_angle_rotator_unit_tb.sv
